@@ design/frrm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frrm_pkg
// Shared types and constants of the flash record ring manager.
// ----------------------------------------------------------------------------
package frrm_pkg;

  localparam int SLOT_COUNT      = 1024;
  localparam int SLOT_W          = 10;
  localparam int RING_W          = 11;
  localparam int SLOTS_PER_SECTOR = 4;
  localparam int SEC_W           = 2;
  localparam int SLOT_SHIFT      = 10;
  localparam int SLOT_BYTES      = 1024;
  localparam int HEADER_BYTES    = 8;
  localparam int HDR_W           = 18;
  localparam int SPAN_W          = 7;
  localparam int RING_MIN        = 4;

  localparam logic [1:0] FN_APPEND = 2'd0;
  localparam logic [1:0] FN_PEEK   = 2'd1;
  localparam logic [1:0] FN_POP    = 2'd2;
  localparam logic [1:0] FN_RSVD   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_NO_SPACE  = 3'd3;
  localparam logic [2:0] ST_TOO_SMALL = 3'd4;

  typedef struct packed {
    logic              wr;
    logic [RING_W-1:0] ring;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [HDR_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [SPAN_W-1:0] span_of(input logic [15:0] len);
    logic [16:0] s;
    s = {1'b0, len} + 17'(HEADER_BYTES + SLOT_BYTES - 1);
    return s[16:SLOT_SHIFT];
  endfunction

endpackage
`default_nettype wire

@@ design/frrm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frrm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/frrm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frrm_ctrl
// Sequencer for append, peek and pop over the slot header memory.
// ----------------------------------------------------------------------------
module frrm_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire frrm_pkg::cfg_t                  cfg_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [1:0]                      func_i,
  input  wire logic [15:0]                     rec_len_i,
  input  wire logic                            critical_i,
  input  wire logic [15:0]                     max_len_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [2:0]                      status_o,
  output      logic [15:0]                     length_out_o,
  output      logic [9:0]                      slot_out_o,
  output      logic [31:0]                     seq_out_o,
  output      logic [9:0]                      erase_first_slot_o,
  output      logic [8:0]                      erase_sectors_o,
  output      logic [10:0]                     count_now_o,
  output      logic [31:0]                     oldest_seq_o,
  output      logic [31:0]                     newest_seq_o,
  output      frrm_pkg::mem_req_t              mem_o,
  input  wire logic [frrm_pkg::HDR_W-1:0]      mem_rdata_i
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEC, S_WALK_RD, S_WALK_EV, S_ERASE, S_WRITE,
    S_PK_RD, S_PK_EV, S_POP_RD, S_POP_EV, S_DONE
  } state_e;

  localparam int SW = frrm_pkg::SLOT_W;
  localparam int RW = frrm_pkg::RING_W;
  localparam int NW = frrm_pkg::SPAN_W;

  state_e              state_q;
  logic [SW-1:0]       clr_q;
  logic [SW-1:0]       head_q, tail_q, t_q;
  logic [RW-1:0]       cnt_q, rem_q;
  logic [31:0]         seq_q;
  logic [NW-1:0]       n_q, k_q;
  logic [frrm_pkg::SEC_W-1:0] j_q;
  logic [15:0]         len_q, maxl_q;
  logic                crit_q;
  logic [2:0]          status_q;
  logic [15:0]         len_out_q;
  logic [SW-1:0]       slot_out_q, er_first_q;
  logic [31:0]         seq_out_q;
  logic [8:0]          er_cnt_q;
  logic                out_valid_q;

  logic [RW-1:0]       ring;
  logic [NW-1:0]       in_span;
  logic [RW-1:0]       head_plus_in, head_plus_n, t_plus_span, t_plus_one;
  logic [SW-1:0]       head_wrap, t_next, t_inc, sec0;
  logic [15:0]         h_len;
  logic                h_valid, h_crit, overlap;
  logic [NW-1:0]       h_span;
  logic [31:0]         newest, cm1, oldest;
  logic                out_load;

  assign ring    = cfg_i.ring;
  assign in_span = frrm_pkg::span_of(rec_len_i);
  assign head_plus_in = {1'b0, head_q} + RW'(in_span);
  assign head_plus_n  = {1'b0, head_q} + RW'(n_q);
  assign head_wrap    = (head_plus_n == ring) ? '0 : head_plus_n[SW-1:0];
  assign sec0         = head_q + SW'(k_q);

  assign h_len   = mem_rdata_i[15:0];
  assign h_valid = mem_rdata_i[17] && (h_len != 16'd0) &&
                   ({5'd0, h_len} + 21'(frrm_pkg::HEADER_BYTES) <=
                    {ring, {frrm_pkg::SLOT_SHIFT{1'b0}}});
  assign h_crit  = h_valid && mem_rdata_i[16];
  assign h_span  = h_valid ? frrm_pkg::span_of(h_len) : NW'(1);

  assign t_plus_span = {1'b0, t_q} + RW'(h_span);
  assign t_next      = (t_plus_span >= ring) ? SW'(t_plus_span - ring) : t_plus_span[SW-1:0];
  assign t_plus_one  = {1'b0, t_q} + RW'(1);
  assign t_inc       = (t_plus_one == ring) ? '0 : t_plus_one[SW-1:0];
  assign overlap = ({1'b0, t_q} < {1'b0, sec0} + RW'(frrm_pkg::SLOTS_PER_SECTOR)) &&
                   ({1'b0, sec0} < t_plus_span);

  assign newest = (seq_q == 32'd0) ? 32'd0 : seq_q - 32'd1;
  assign cm1    = {21'd0, cnt_q} - 32'd1;
  assign oldest = ((cnt_q != '0) && (newest >= cm1)) ? newest - cm1 : 32'd0;

  assign out_load    = (state_q == S_DONE) && !cfg_i.wr && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    mem_o.we    = 1'b0;
    mem_o.waddr = clr_q;
    mem_o.wdata = '0;
    mem_o.raddr = t_q;
    unique case (state_q)
      S_CLEAR: mem_o.we = 1'b1;
      S_ERASE: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = sec0 + SW'(j_q);
      end
      S_WRITE: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = head_q + SW'(k_q);
        mem_o.wdata = (k_q == '0) ? {1'b1, crit_q, len_q} : '0;
      end
      default: mem_o.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.wr) begin
        head_q  <= '0;
        tail_q  <= '0;
        cnt_q   <= '0;
        clr_q   <= '0;
        state_q <= S_CLEAR;
      end else begin
        unique case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + SW'(1);
            if (clr_q == SW'(frrm_pkg::SLOT_COUNT - 1)) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: if (in_valid_i) begin
            len_q      <= rec_len_i;
            crit_q     <= critical_i;
            maxl_q     <= max_len_i;
            status_q   <= frrm_pkg::ST_OK;
            len_out_q  <= '0;
            slot_out_q <= '0;
            seq_out_q  <= '0;
            er_first_q <= '0;
            er_cnt_q   <= '0;
            t_q        <= tail_q;
            rem_q      <= '0;
            unique case (func_i) inside
              frrm_pkg::FN_APPEND: begin
                if (rec_len_i == 16'd0 || RW'(in_span) > ring) begin
                  status_q <= frrm_pkg::ST_BAD_LEN;
                  state_q  <= S_DONE;
                end else begin
                  n_q <= in_span;
                  k_q <= '0;
                  if (head_plus_in > ring) begin
                    head_q <= '0;
                    if (cnt_q == '0) begin
                      tail_q <= '0;
                    end
                  end
                  state_q <= S_SEC;
                end
              end
              frrm_pkg::FN_PEEK, frrm_pkg::FN_POP: begin
                if (cnt_q == '0) begin
                  status_q <= frrm_pkg::ST_EMPTY;
                  state_q  <= S_DONE;
                end else begin
                  state_q <= (func_i == frrm_pkg::FN_PEEK) ? S_PK_RD : S_POP_RD;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
          S_SEC: begin
            if (k_q == n_q) begin
              k_q     <= '0;
              state_q <= S_WRITE;
            end else if (sec0[frrm_pkg::SEC_W-1:0] != '0) begin
              k_q <= k_q + NW'(1);
            end else begin
              t_q     <= tail_q;
              rem_q   <= cnt_q;
              state_q <= S_WALK_RD;
            end
          end
          S_WALK_RD: begin
            if (rem_q == '0) begin
              tail_q  <= t_q;
              cnt_q   <= rem_q;
              j_q     <= '0;
              state_q <= S_ERASE;
            end else begin
              state_q <= S_WALK_EV;
            end
          end
          S_WALK_EV: begin
            if (!overlap) begin
              tail_q  <= t_q;
              cnt_q   <= rem_q;
              j_q     <= '0;
              state_q <= S_ERASE;
            end else if (!crit_q && h_crit) begin
              status_q <= frrm_pkg::ST_NO_SPACE;
              state_q  <= S_DONE;
            end else begin
              t_q     <= t_next;
              rem_q   <= rem_q - RW'(1);
              state_q <= S_WALK_RD;
            end
          end
          S_ERASE: begin
            j_q <= j_q + frrm_pkg::SEC_W'(1);
            if (j_q == frrm_pkg::SEC_W'(frrm_pkg::SLOTS_PER_SECTOR - 1)) begin
              if (er_cnt_q == '0) begin
                er_first_q <= sec0;
              end
              er_cnt_q <= er_cnt_q + 9'd1;
              k_q      <= k_q + NW'(1);
              state_q  <= S_SEC;
            end
          end
          S_WRITE: begin
            k_q <= k_q + NW'(1);
            if (k_q == n_q - NW'(1)) begin
              seq_out_q  <= seq_q;
              seq_q      <= seq_q + 32'd1;
              slot_out_q <= head_q;
              head_q     <= head_wrap;
              cnt_q      <= cnt_q + RW'(1);
              state_q    <= S_DONE;
            end
          end
          S_PK_RD: state_q <= S_PK_EV;
          S_PK_EV: begin
            if (h_valid) begin
              if (rem_q != '0) begin
                tail_q <= t_q;
                cnt_q  <= cnt_q - RW'(1);
              end
              len_out_q  <= h_len;
              slot_out_q <= t_q;
              if (h_len >= maxl_q) begin
                status_q <= frrm_pkg::ST_TOO_SMALL;
              end
              state_q <= S_DONE;
            end else if (rem_q == ring - RW'(1)) begin
              tail_q   <= head_q;
              cnt_q    <= '0;
              status_q <= frrm_pkg::ST_EMPTY;
              state_q  <= S_DONE;
            end else begin
              t_q     <= t_inc;
              rem_q   <= rem_q + RW'(1);
              state_q <= S_PK_RD;
            end
          end
          S_POP_RD: state_q <= S_POP_EV;
          S_POP_EV: begin
            slot_out_q <= t_q;
            tail_q     <= t_next;
            cnt_q      <= cnt_q - RW'(1);
            state_q    <= S_DONE;
          end
          S_DONE: if (out_load) begin
            status_o           <= status_q;
            length_out_o       <= len_out_q;
            slot_out_o         <= slot_out_q;
            seq_out_o          <= seq_out_q;
            erase_first_slot_o <= er_first_q;
            erase_sectors_o    <= er_cnt_q;
            count_now_o        <= cnt_q;
            oldest_seq_o       <= oldest;
            newest_seq_o       <= (cnt_q == '0) ? 32'd0 : newest;
            state_q            <= S_IDLE;
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RW'(frrm_pkg::SLOT_COUNT))
    else $error("live count beyond slot count");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !cfg_i.wr |=> !in_ready_o)
    else $error("accepted transaction left block idle");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> ({1'b0, head_q} < ring) && ({1'b0, tail_q} < ring))
    else $error("ring pointer out of range");
`endif

endmodule
`default_nettype wire

@@ design/flash_record_ring_manager_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flash_record_ring_manager_top
// Header bookkeeping of a ring of flash slots holding variable-length records.
// ----------------------------------------------------------------------------
// Usage: one transaction on the in channel (append, peek or pop) gives one
// transaction on the out channel. The in side is taken only while the
// sequencer is idle; one operation runs at a time.
// Flow: for each sector that an append starts, it first retires the live
// records that overlap the sector and then erases it; it then writes a header
// to every slot it spans. A peek scans further slots on resync, up to the
// ring length; a pop reads the tail header; rejected, empty or undefined
// requests go straight to the result. The result becomes valid in the same
// cycle as the sequencer returns to idle.
// The header memory has registered read data and takes one write per cycle.
// Reset, and any write of slots_in_use, starts a clearing pass over all 1024
// slot headers; in_ready_o stays low until it finishes.
// A stalled receiver holds the result in the output register; the next
// transaction may be accepted meanwhile, its result waits until the register
// frees.
// ----------------------------------------------------------------------------
module flash_record_ring_manager_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] rec_len_i,
  input  wire logic        critical_i,
  input  wire logic [15:0] max_len_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [2:0]  status_o,
  output      logic [15:0] length_out_o,
  output      logic [9:0]  slot_out_o,
  output      logic [31:0] seq_out_o,
  output      logic [9:0]  erase_first_slot_o,
  output      logic [8:0]  erase_sectors_o,
  output      logic [10:0] count_now_o,
  output      logic [31:0] oldest_seq_o,
  output      logic [31:0] newest_seq_o
);

  localparam int RW = frrm_pkg::RING_W;

  logic [RW-1:0]               slots_q;
  logic [RW-1:0]               ring_len;
  logic                        wr_hit;
  frrm_pkg::cfg_t              cfg;
  frrm_pkg::mem_req_t          mem_req;
  logic [frrm_pkg::HDR_W-1:0]  mem_rdata;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {21'd0, slots_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= RW'(frrm_pkg::SLOT_COUNT);
    end else if (wr_hit) begin
      slots_q <= pwdata[RW-1:0];
    end
  end

  assign ring_len = (slots_q < RW'(frrm_pkg::RING_MIN)) ? RW'(frrm_pkg::RING_MIN) :
                    (slots_q > RW'(frrm_pkg::SLOT_COUNT)) ? RW'(frrm_pkg::SLOT_COUNT) :
                    slots_q;

  assign cfg.wr   = wr_hit;
  assign cfg.ring = ring_len;

  frrm_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .rec_len_i          (rec_len_i),
    .critical_i         (critical_i),
    .max_len_i          (max_len_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .length_out_o       (length_out_o),
    .slot_out_o         (slot_out_o),
    .seq_out_o          (seq_out_o),
    .erase_first_slot_o (erase_first_slot_o),
    .erase_sectors_o    (erase_sectors_o),
    .count_now_o        (count_now_o),
    .oldest_seq_o       (oldest_seq_o),
    .newest_seq_o       (newest_seq_o),
    .mem_o              (mem_req),
    .mem_rdata_i        (mem_rdata)
  );

  frrm_ram #(
    .WIDTH (frrm_pkg::HDR_W),
    .DEPTH (frrm_pkg::SLOT_COUNT)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

@@ tb/flash_record_ring_manager_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_record_ring_manager_top_tb
// Self-checking bench for the flash record ring manager. A header-level
// predictor tracks the slot headers, head, tail, live count and sequence
// counter; every result is compared field by field with the oldest
// prediction while both handshakes idle and stall at random across several
// ring lengths.
// ----------------------------------------------------------------------------
module flash_record_ring_manager_top_tb;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] length;
    logic [9:0]  slot;
    logic [31:0] seq;
    logic [9:0]  erase_first;
    logic [8:0]  erase_sectors;
    logic [10:0] count;
    logic [31:0] oldest;
    logic [31:0] newest;
  } ring_result_t;

  class ring_scoreboard;
    logic [frrm_pkg::HDR_W-1:0] hdr[frrm_pkg::SLOT_COUNT];
    int unsigned head, tail, live, ring_reg;
    logic [31:0] next_seq;
    ring_result_t pending[$];
    int errors;

    function new();
      foreach (hdr[i]) hdr[i] = '0;
      head = 0; tail = 0; live = 0; next_seq = 0; ring_reg = 1024; errors = 0;
    endfunction

    function void set_ring(logic [10:0] v);
      ring_reg = 32'(v);
      foreach (hdr[i]) hdr[i] = '0;
      head = 0; tail = 0; live = 0;
    endfunction

    function int unsigned ring_len();
      if (ring_reg < frrm_pkg::RING_MIN) return frrm_pkg::RING_MIN;
      if (ring_reg > frrm_pkg::SLOT_COUNT) return frrm_pkg::SLOT_COUNT;
      return ring_reg;
    endfunction

    function int unsigned span_slots(int unsigned len);
      return (len + frrm_pkg::HEADER_BYTES + frrm_pkg::SLOT_BYTES - 1) / frrm_pkg::SLOT_BYTES;
    endfunction

    function int start_len(int unsigned s);
      int unsigned len;
      if (s >= frrm_pkg::SLOT_COUNT || !hdr[s][17]) return -1;
      len = 32'(hdr[s][15:0]);
      if (len == 0 || len + frrm_pkg::HEADER_BYTES > ring_len() * frrm_pkg::SLOT_BYTES)
        return -1;
      return len;
    endfunction

    function int unsigned start_span(int unsigned s);
      int l;
      l = start_len(s);
      return (l < 0) ? 1 : span_slots(l);
    endfunction

    function bit start_alarm(int unsigned s);
      return start_len(s) >= 0 && hdr[s][16];
    endfunction

    function bit overlaps(int unsigned a, int unsigned na, int unsigned b, int unsigned nb);
      return (a < b + nb) && (b < a + na);
    endfunction

    function void note_input(logic [1:0] fn, logic [15:0] len, logic crit, logic [15:0] maxl);
      ring_result_t r;
      int unsigned ring, n, sec0, t, rem, ts;
      int l;
      bit found;
      logic [31:0] nw;
      r = '0;
      ring = ring_len();
      if (head >= ring) head = 0;
      if (tail >= ring) tail = 0;
      case (fn)
        frrm_pkg::FN_APPEND: begin
          n = span_slots(32'(len));
          if (len == 0 || n > ring) begin
            r.status = frrm_pkg::ST_BAD_LEN;
          end else begin
            if (head + n > ring) begin
              head = 0;
              if (live == 0) tail = 0;
            end
            for (int k = 0; k < n && r.status == frrm_pkg::ST_OK; k++) begin
              sec0 = head + k;
              if (sec0 % frrm_pkg::SLOTS_PER_SECTOR != 0) continue;
              if (!crit) begin
                t = tail; rem = live;
                while (rem > 0) begin
                  ts = start_span(t);
                  if (!overlaps(t, ts, sec0, frrm_pkg::SLOTS_PER_SECTOR)) break;
                  if (start_alarm(t)) begin
                    r.status = frrm_pkg::ST_NO_SPACE;
                    break;
                  end
                  t = (t + ts) % ring;
                  rem--;
                end
                if (r.status != frrm_pkg::ST_OK) break;
              end
              while (live > 0) begin
                ts = start_span(tail);
                if (!overlaps(tail, ts, sec0, frrm_pkg::SLOTS_PER_SECTOR)) break;
                tail = (tail + ts) % ring;
                live--;
              end
              for (int j = 0; j < frrm_pkg::SLOTS_PER_SECTOR; j++)
                if (sec0 + j < frrm_pkg::SLOT_COUNT) hdr[sec0 + j] = '0;
              if (r.erase_sectors == 0) r.erase_first = 10'(sec0);
              r.erase_sectors++;
            end
            if (r.status == frrm_pkg::ST_OK) begin
              r.seq = next_seq;
              next_seq++;
              hdr[head] = {1'b1, crit, len};
              for (int j = 1; j < n; j++) hdr[head + j] = '0;
              r.slot = 10'(head);
              head = (head + n) % ring;
              live++;
            end
          end
        end
        frrm_pkg::FN_PEEK: begin
          if (live == 0) begin
            r.status = frrm_pkg::ST_EMPTY;
          end else begin
            l = start_len(tail);
            if (l < 0) begin
              found = 0;
              for (int k = 1; k < ring; k++) begin
                if (start_len((tail + k) % ring) >= 0) begin
                  tail = (tail + k) % ring;
                  live--;
                  found = 1;
                  break;
                end
              end
              if (!found) begin
                tail = head; live = 0; r.status = frrm_pkg::ST_EMPTY;
              end else begin
                l = start_len(tail);
              end
            end
            if (r.status == frrm_pkg::ST_OK && l >= 0) begin
              r.length = 16'(l);
              r.slot = 10'(tail);
              if (l >= int'(maxl)) r.status = frrm_pkg::ST_TOO_SMALL;
            end
          end
        end
        frrm_pkg::FN_POP: begin
          if (live == 0) begin
            r.status = frrm_pkg::ST_EMPTY;
          end else begin
            r.slot = 10'(tail);
            tail = (tail + start_span(tail)) % ring;
            live--;
          end
        end
        default: ;
      endcase
      nw = (next_seq != 0) ? next_seq - 1 : 32'd0;
      r.oldest = (live != 0 && nw >= live - 1) ? nw - (live - 1) : 32'd0;
      r.newest = (live == 0) ? 32'd0 : nw;
      r.count = 11'(live);
      pending.push_back(r);
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result, status %0d", got.status);
        return;
      end
      exp = pending.pop_front();
      if (got != exp) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp st=%0d len=%0d slot=%0d seq=%0d ef=%0d es=%0d cnt=%0d",
                   exp.status, exp.length, exp.slot, exp.seq, exp.erase_first,
                   exp.erase_sectors, exp.count);
          $display("         exp old=%0d new=%0d", exp.oldest, exp.newest);
          $display("         got st=%0d len=%0d slot=%0d seq=%0d ef=%0d es=%0d cnt=%0d",
                   got.status, got.length, got.slot, got.seq, got.erase_first,
                   got.erase_sectors, got.count);
          $display("         got old=%0d new=%0d", got.oldest, got.newest);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  func_i;
  logic [15:0] rec_len_i, max_len_i;
  logic        critical_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] length_out_o;
  logic [9:0]  slot_out_o, erase_first_slot_o;
  logic [31:0] seq_out_o, oldest_seq_o, newest_seq_o;
  logic [8:0]  erase_sectors_o;
  logic [10:0] count_now_o;
  ring_result_t got;

  ring_scoreboard sb;
  int  idle_left = 0;
  int  hold_left = 0;
  bit  hold_go, burst_mode;

  assign got = {status_o, length_out_o, slot_out_o, seq_out_o, erase_first_slot_o,
                erase_sectors_o, count_now_o, oldest_seq_o, newest_seq_o};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  flash_record_ring_manager_top u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .func_i, .rec_len_i, .critical_i, .max_len_i,
    .out_valid_o, .out_ready_i,
    .status_o, .length_out_o, .slot_out_o, .seq_out_o, .erase_first_slot_o,
    .erase_sectors_o, .count_now_o, .oldest_seq_o, .newest_seq_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(got);
      idle_left = burst_mode ? 0 : $urandom_range(0, 11);
    end
    if (hold_go) begin
      hold_go = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (idle_left > 0) begin
      idle_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send(logic [1:0] fn, logic [15:0] len, logic crit, logic [15:0] maxl);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    rec_len_i  <= len;
    critical_i <= crit;
    max_len_i  <= maxl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(fn, len, crit, maxl);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_ring(logic [10:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_ring(v);
  endtask

  task automatic random_item();
    int p;
    logic [1:0]  fn;
    logic [15:0] len;
    p = $urandom_range(0, 99);
    fn = (p < 60) ? frrm_pkg::FN_APPEND : (p < 80) ? frrm_pkg::FN_PEEK :
         (p < 95) ? frrm_pkg::FN_POP : frrm_pkg::FN_RSVD;
    p = $urandom_range(0, 99);
    len = (p < 80) ? 16'($urandom_range(1, 3000)) : (p < 90) ? 16'($urandom) :
          (p < 95) ? 16'd0 : 16'hFFFF;
    send(fn, len, $urandom_range(0, 3) == 0, 16'($urandom));
  endtask

  initial begin
    logic [10:0] rings[6] = '{11'd4, 11'd2047, 11'd0, 11'd13, 11'd64, 11'd1024};
    sb = new();
    rst_ni <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid_i <= 1'b0; func_i <= frrm_pkg::FN_APPEND; rec_len_i <= '0;
    critical_i <= 1'b0; max_len_i <= '0;
    hold_go = 0; burst_mode = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(frrm_pkg::FN_APPEND, 16'd0, 1'b0, 16'd0);
    send(frrm_pkg::FN_PEEK, 16'd0, 1'b0, 16'hFFFF);
    send(frrm_pkg::FN_POP, 16'd0, 1'b0, 16'd0);
    send(frrm_pkg::FN_RSVD, 16'hFFFF, 1'b1, 16'hFFFF);
    send(frrm_pkg::FN_APPEND, 16'd1016, 1'b0, 16'd0);
    send(frrm_pkg::FN_APPEND, 16'd1017, 1'b1, 16'd0);
    send(frrm_pkg::FN_APPEND, 16'hFFFF, 1'b1, 16'd0);
    send(frrm_pkg::FN_PEEK, 16'd0, 1'b0, 16'd0);
    send(frrm_pkg::FN_PEEK, 16'd0, 1'b0, 16'hFFFF);
    send(frrm_pkg::FN_POP, 16'd0, 1'b0, 16'd0);
    send(frrm_pkg::FN_PEEK, 16'd0, 1'b0, 16'd1017);
    send(frrm_pkg::FN_PEEK, 16'd0, 1'b0, 16'd1018);

    write_ring(11'd4);
    send(frrm_pkg::FN_APPEND, 16'd4089, 1'b0, 16'd0);
    send(frrm_pkg::FN_APPEND, 16'd1000, 1'b1, 16'd0);
    send(frrm_pkg::FN_APPEND, 16'd2000, 1'b0, 16'd0);
    send(frrm_pkg::FN_APPEND, 16'd3000, 1'b0, 16'd0);
    send(frrm_pkg::FN_APPEND, 16'd4088, 1'b1, 16'd0);
    send(frrm_pkg::FN_PEEK, 16'd0, 1'b0, 16'hFFFF);
    send(frrm_pkg::FN_APPEND, 16'd10, 1'b0, 16'd0);
    send(frrm_pkg::FN_POP, 16'd0, 1'b0, 16'd0);
    send(frrm_pkg::FN_PEEK, 16'd0, 1'b0, 16'hFFFF);

    for (int ph = 0; ph < 6; ph++) begin
      write_ring(rings[ph]);
      for (int i = 0; i < 165; i++) begin
        if (i % 40 == 0) burst_mode = ~burst_mode;
        if (ph == 1 && i == 50) hold_go = 1;
        if (ph == 3 && i == 80) drain();
        random_item();
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
design/frrm_pkg.sv
design/frrm_ram.sv
design/frrm_ctrl.sv
design/flash_record_ring_manager_top.sv
tb/flash_record_ring_manager_top_tb.sv
